/* design/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication checked outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

/* design/uhd_pkg.sv */
package uhd_pkg;

  // Decoder automaton states
  localparam logic [3:0] DFA_ACC = 4'd0;
  localparam logic [3:0] DFA_REJ = 4'd1;
  localparam logic [3:0] DFA_MAX = 4'd8;
  localparam logic [3:0] DFA_ROWS = 4'd9;

  // Byte classes (columns of the transition table)
  localparam logic [3:0] CLS_ASCII    = 4'd0;   // 00-7F
  localparam logic [3:0] CLS_CONT_LO  = 4'd1;   // 80-8F
  localparam logic [3:0] CLS_LEAD2    = 4'd2;   // C2-DF
  localparam logic [3:0] CLS_LEAD3    = 4'd3;   // E1-EC, EE-EF
  localparam logic [3:0] CLS_ED       = 4'd4;
  localparam logic [3:0] CLS_F4       = 4'd5;
  localparam logic [3:0] CLS_LEAD4    = 4'd6;   // F1-F3
  localparam logic [3:0] CLS_CONT_HI  = 4'd7;   // A0-BF
  localparam logic [3:0] CLS_BAD      = 4'd8;   // C0, C1, F5-FF
  localparam logic [3:0] CLS_CONT_MID = 4'd9;   // 90-9F
  localparam logic [3:0] CLS_E0       = 4'd10;
  localparam logic [3:0] CLS_F0       = 4'd11;

  // Characters of interest
  localparam logic [20:0] CP_REPL = 21'h00FFFD;
  localparam logic [20:0] CP_LF   = 21'h00000A;
  localparam logic [20:0] CP_CR   = 21'h00000D;
  localparam logic [20:0] CP_TAB  = 21'h000009;
  localparam logic [7:0]  BYTE_LF = 8'h0A;

  // Error kinds
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_TRUNC   = 2'd2;

  localparam logic [7:0]  TAB_STOP_RST = 8'd8;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Transition table: row = state, column = byte class
  localparam logic [3:0] NEXT_TAB [9][12] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT_LEAD,
    ST_EMIT_FIN,
    ST_TAB
  } uhd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic emit_lead;
    logic emit_fin;
    logic tab_start;
    logic tab_update;
  } uhd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lead_valid;
    logic fin_valid;
    logic fin_is_tab;
    logic out_free;
    logic div_done;
  } uhd_sts_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] cls;
    if (b < 8'h80)       cls = CLS_ASCII;
    else if (b < 8'h90)  cls = CLS_CONT_LO;
    else if (b < 8'hA0)  cls = CLS_CONT_MID;
    else if (b < 8'hC0)  cls = CLS_CONT_HI;
    else if (b < 8'hC2)  cls = CLS_BAD;
    else if (b < 8'hE0)  cls = CLS_LEAD2;
    else if (b == 8'hE0) cls = CLS_E0;
    else if (b == 8'hED) cls = CLS_ED;
    else if (b < 8'hF0)  cls = CLS_LEAD3;
    else if (b == 8'hF0) cls = CLS_F0;
    else if (b < 8'hF4)  cls = CLS_LEAD4;
    else if (b == 8'hF4) cls = CLS_F4;
    else                 cls = CLS_BAD;
    return cls;
  endfunction

  function automatic logic [3:0] dfa_next(input logic [3:0] s, input logic [3:0] cls);
    logic [3:0] row;
    row = (s >= DFA_ROWS) ? (s - DFA_ROWS) : s;
    return NEXT_TAB[row][cls];
  endfunction

  // Noncharacters and control codes that HTML input may not carry
  function automatic logic is_forbidden(input logic [20:0] c);
    return ((c >= 21'h1) && (c <= 21'h8)) || (c == 21'hB) ||
           ((c >= 21'hE) && (c <= 21'h1F)) || ((c >= 21'h7F) && (c <= 21'h9F)) ||
           ((c >= 21'hFDD0) && (c <= 21'hFDEF)) || (c[15:0] >= 16'hFFFE);
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage

/* design/utf8_html_input_decoder_unit.sv */
// UTF-8 byte stream decoder with HTML input preprocessing.
// Input channel (in_valid/in_ready): one stream byte per transaction, with
// in_end_of_input marking the final byte. Result channel (out_valid/out_ready):
// one decoded character per transaction with its error kind and the line,
// column and byte offset where it starts; out_last_of_run flags the final
// result caused by a byte. A byte yields zero, one or two results.
// cfg_we/cfg_wdata write the tab stop (reset 8; zero acts as 1); write it
// only while the block is idle.
// Sequencing: the controller walks accept, decode, leading result, final
// result. A leading result (held-back LF or replacement for a broken
// sequence) goes out before the final result of the same byte. After a tab
// character the controller waits for the bit-serial column remainder unit.
// A single result register sits on the output: when the receiver stalls the
// next byte is still accepted and decoded, and the block waits only when a
// new result needs that register.
// Reset (rst_n low, synchronous) returns the decoder to its start state,
// clears the held CR, sets line and column to 1 and the offset to 0.
module utf8_html_input_decoder_unit
  import uhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_char_code,
  output logic [1:0]  out_error_kind,
  output logic [31:0] out_line_number,
  output logic [31:0] out_column_number,
  output logic [31:0] out_byte_offset,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  uhd_cmd_t cmd;
  uhd_sts_t sts;

  uhd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uhd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_byte           (in_byte),
    .in_end_of_input   (in_end_of_input),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_code     (out_char_code),
    .out_error_kind    (out_error_kind),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_byte_offset   (out_byte_offset),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

/* design/uhd_tabrem.sv */
// Remainder of the column by the tab stop, one quotient bit per cycle
module uhd_tabrem
  import uhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic [7:0]  rem,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [7:0]  dvsr_r, dvsr_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [8:0]  trial;
  logic [8:0]  diff;

  // Restoring step: shift in next dividend bit, subtract when it fits
  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvsr_nxt = dvsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvsr_nxt = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvsr_r}) ? diff[7:0] : trial[7:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    dvsr_r <= dvsr_nxt;
    rem_r  <= rem_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_done_after_busy, done_r, !busy_r && $past(busy_r))

endmodule

/* design/uhd_ctrl.sv */
// Sequencer: take a byte, decode it, hand out up to two results and, after a tab, wait for the new column
module uhd_ctrl
  import uhd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  uhd_sts_t sts,
  output uhd_cmd_t cmd
);

  uhd_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_EMIT_LEAD;
      end
      ST_EMIT_LEAD: begin
        if (!sts.lead_valid || sts.out_free) begin
          state_nxt = sts.fin_valid ? ST_EMIT_FIN : ST_IDLE;
        end
      end
      ST_EMIT_FIN: begin
        if (!sts.fin_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          state_nxt = sts.fin_is_tab ? ST_TAB : ST_IDLE;
        end
      end
      ST_TAB: begin
        if (sts.div_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
      end
      ST_EMIT_LEAD: begin
        cmd.emit_lead = sts.lead_valid && sts.out_free;
      end
      ST_EMIT_FIN: begin
        cmd.emit_fin  = sts.fin_valid && sts.out_free;
        cmd.tab_start = sts.fin_valid && sts.out_free && sts.fin_is_tab;
      end
      ST_TAB: begin
        cmd.tab_update = sts.div_done;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_emit_needs_slot, cmd.emit_lead || cmd.emit_fin, sts.out_free)
  `ASSERT_CLK(a_tab_waits, cmd.tab_start |=> state_r == ST_TAB)

endmodule

/* design/uhd_dp.sv */
// Decoder state, position counters, result register
module uhd_dp
  import uhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  uhd_cmd_t    cmd,
  output uhd_sts_t    sts,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_char_code,
  output logic [1:0]  out_error_kind,
  output logic [31:0] out_line_number,
  output logic [31:0] out_column_number,
  output logic [31:0] out_byte_offset,
  output logic        out_last_of_run
);

  // Configuration and captured byte
  logic [7:0]  ts_cfg_r;
  logic [7:0]  byte_r;
  logic        end_r;

  // Decoder state
  logic [3:0]  dfa_r, dfa_nxt;
  logic [20:0] part_r, part_nxt;
  logic [2:0]  bis_r, bis_nxt;
  logic        pcr_r, pcr_nxt;

  // Position counters
  logic [31:0] line_r, line_nxt;
  logic [31:0] col_r, col_nxt;
  logic [31:0] off_r, off_nxt;

  // Result plan for the current byte
  logic        lead_v_r, lead_v_nxt;
  logic [20:0] lead_cp_r, lead_cp_nxt;
  logic [1:0]  lead_err_r, lead_err_nxt;
  logic [2:0]  lead_w_r, lead_w_nxt;
  logic        fin_v_r, fin_v_nxt;
  logic [20:0] fin_cp_r, fin_cp_nxt;
  logic [1:0]  fin_err_r, fin_err_nxt;
  logic [2:0]  fin_w_r, fin_w_nxt;
  logic        bump;

  // Result register
  logic        ov_r, ov_nxt;
  logic [20:0] ocp_r;
  logic [1:0]  oerr_r;
  logic [31:0] oline_r, ocol_r, ooff_r;
  logic        olast_r;

  logic        emit;
  logic [20:0] e_cp;
  logic [1:0]  e_err;
  logic [2:0]  e_w;
  logic        e_last;
  logic        out_free;

  logic [7:0]  ts_eff;
  logic [7:0]  rem;
  logic        div_done;
  logic [31:0] tab_base;
  logic [31:0] tab_col;

  // Decode one byte into new automaton state and up to two results
  always_comb begin
    logic [3:0]  cls;
    logic [3:0]  nx;
    logic        fresh;
    logic        taken;
    logic [20:0] cp;
    logic [2:0]  w;
    cls          = byte_class(byte_r);
    nx           = DFA_ACC;
    fresh        = 1'b1;
    taken        = 1'b0;
    cp           = '0;
    w            = '0;
    dfa_nxt      = dfa_r;
    part_nxt     = part_r;
    bis_nxt      = bis_r;
    pcr_nxt      = pcr_r;
    lead_v_nxt   = lead_v_r;
    lead_cp_nxt  = lead_cp_r;
    lead_err_nxt = lead_err_r;
    lead_w_nxt   = lead_w_r;
    fin_v_nxt    = fin_v_r;
    fin_cp_nxt   = fin_cp_r;
    fin_err_nxt  = fin_err_r;
    fin_w_nxt    = fin_w_r;
    bump         = 1'b0;
    if (cmd.decode) begin
      lead_v_nxt = 1'b0;
      fin_v_nxt  = 1'b0;
      pcr_nxt    = 1'b0;
      if (pcr_r) begin
        // held CR becomes LF
        lead_v_nxt   = 1'b1;
        lead_cp_nxt  = CP_LF;
        lead_err_nxt = ERR_NONE;
        lead_w_nxt   = 3'd1;
      end
      if (pcr_r && (byte_r == BYTE_LF)) begin
        // CR LF: one LF reported at the LF's offset
        bump = 1'b1;
      end else begin
        // continuation of an open sequence
        if (dfa_r != DFA_ACC) begin
          nx = dfa_next(dfa_r, cls);
          if (nx == DFA_REJ) begin
            lead_v_nxt   = 1'b1;
            lead_cp_nxt  = CP_REPL;
            lead_err_nxt = ERR_INVALID;
            lead_w_nxt   = bis_r;
            dfa_nxt      = DFA_ACC;
            bis_nxt      = '0;
            part_nxt     = '0;
          end else begin
            part_nxt = {part_r[14:0], byte_r[5:0]};
            bis_nxt  = bis_r + 3'd1;
            dfa_nxt  = nx;
            fresh    = 1'b0;
          end
        end
        // byte starts a new sequence
        if (fresh) begin
          nx = dfa_next(DFA_ACC, cls);
          if (nx == DFA_REJ) begin
            part_nxt    = '0;
            fin_v_nxt   = 1'b1;
            fin_cp_nxt  = CP_REPL;
            fin_err_nxt = ERR_INVALID;
            fin_w_nxt   = 3'd1;
            taken       = 1'b1;
          end else begin
            part_nxt = {13'b0, (8'hFF >> cls) & byte_r};
            bis_nxt  = 3'd1;
            dfa_nxt  = nx;
          end
        end
        if (!taken) begin
          if (dfa_nxt == DFA_ACC) begin
            // complete character
            cp       = part_nxt;
            w        = bis_nxt;
            part_nxt = '0;
            bis_nxt  = '0;
            if (cp == CP_CR) begin
              if (end_r) begin
                fin_v_nxt   = 1'b1;
                fin_cp_nxt  = CP_LF;
                fin_err_nxt = ERR_NONE;
                fin_w_nxt   = w;
              end else begin
                pcr_nxt = 1'b1;
              end
            end else if (is_forbidden(cp)) begin
              fin_v_nxt   = 1'b1;
              fin_cp_nxt  = CP_REPL;
              fin_err_nxt = ERR_INVALID;
              fin_w_nxt   = w;
            end else begin
              fin_v_nxt   = 1'b1;
              fin_cp_nxt  = cp;
              fin_err_nxt = ERR_NONE;
              fin_w_nxt   = w;
            end
          end else if (end_r) begin
            // stream ends inside a sequence
            fin_v_nxt   = 1'b1;
            fin_cp_nxt  = CP_REPL;
            fin_err_nxt = ERR_TRUNC;
            fin_w_nxt   = bis_nxt;
            dfa_nxt     = DFA_ACC;
            part_nxt    = '0;
            bis_nxt     = '0;
          end
        end
      end
    end
  end

  // Result selection
  assign emit     = cmd.emit_lead || cmd.emit_fin;
  assign e_cp     = cmd.emit_fin ? fin_cp_r : lead_cp_r;
  assign e_err    = cmd.emit_fin ? fin_err_r : lead_err_r;
  assign e_w      = cmd.emit_fin ? fin_w_r : lead_w_r;
  assign e_last   = cmd.emit_fin || !fin_v_r;
  assign out_free = !ov_r || out_ready;

  // Tab: column = column - (column mod stop) + stop, saturated
  assign ts_eff   = (ts_cfg_r == 8'd0) ? 8'd1 : ts_cfg_r;
  assign tab_base = col_r - {24'b0, rem};
  assign tab_col  = sat_add32(tab_base, {24'b0, ts_eff});

  // Counter advance
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    off_nxt  = off_r;
    if (bump) off_nxt = sat_add32(off_r, 32'd1);
    if (emit) begin
      off_nxt = sat_add32(off_r, {29'b0, e_w});
      if (e_cp == CP_LF) begin
        line_nxt = sat_add32(line_r, 32'd1);
        col_nxt  = 32'd1;
      end else if (e_cp != CP_TAB) begin
        col_nxt = sat_add32(col_r, 32'd1);
      end
    end
    if (cmd.tab_update) col_nxt = tab_col;
  end

  // Output valid
  always_comb begin
    ov_nxt = ov_r;
    if (emit)           ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_cfg_r <= TAB_STOP_RST;
      dfa_r    <= DFA_ACC;
      part_r   <= '0;
      bis_r    <= '0;
      pcr_r    <= 1'b0;
      line_r   <= 32'd1;
      col_r    <= 32'd1;
      off_r    <= '0;
      lead_v_r <= 1'b0;
      fin_v_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) ts_cfg_r <= cfg_wdata;
      dfa_r    <= dfa_nxt;
      part_r   <= part_nxt;
      bis_r    <= bis_nxt;
      pcr_r    <= pcr_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      off_r    <= off_nxt;
      lead_v_r <= lead_v_nxt;
      fin_v_r  <= fin_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      end_r  <= in_end_of_input;
    end
    lead_cp_r  <= lead_cp_nxt;
    lead_err_r <= lead_err_nxt;
    lead_w_r   <= lead_w_nxt;
    fin_cp_r   <= fin_cp_nxt;
    fin_err_r  <= fin_err_nxt;
    fin_w_r    <= fin_w_nxt;
    if (emit) begin
      ocp_r   <= e_cp;
      oerr_r  <= e_err;
      oline_r <= line_r;
      ocol_r  <= col_r;
      ooff_r  <= off_r;
      olast_r <= e_last;
    end
  end

  uhd_tabrem u_tabrem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.tab_start),
    .dividend (col_r),
    .divisor  (ts_eff),
    .rem      (rem),
    .done     (div_done)
  );

  assign sts.lead_valid = lead_v_r;
  assign sts.fin_valid  = fin_v_r;
  assign sts.fin_is_tab = (fin_cp_r == CP_TAB);
  assign sts.out_free   = out_free;
  assign sts.div_done   = div_done;

  assign out_valid         = ov_r;
  assign out_char_code     = ocp_r;
  assign out_error_kind    = oerr_r;
  assign out_line_number   = oline_r;
  assign out_column_number = ocol_r;
  assign out_byte_offset   = ooff_r;
  assign out_last_of_run   = olast_r;

`include "assert_macros.svh"

  `ASSERT_CLK(a_pos_nonzero, (line_r != 32'd0) && (col_r != 32'd0))
  `ASSERT_IMPL(a_off_monotonic, $past(rst_n), off_r >= $past(off_r))
  `ASSERT_CLK(a_dfa_range, dfa_r <= DFA_MAX)

endmodule
